// ----- design/b2b_pkg.sv -----
// Shared types, constants and tables of the BLAKE2b hash engine.
package b2b_pkg;

   localparam int DATA_W      = 64;
   localparam int CNT_W       = 4;
   localparam int LEN_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int BLOCK_BYTES = 128;
   localparam int FILL_W      = 8;
   localparam int ROUNDS      = 12;
   localparam int STEPS       = ROUNDS * 16;
   localparam int STEP_W      = 8;

   localparam logic [STEP_W-1:0]    LAST_STEP       = STEP_W'(STEPS - 1);
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH  = 1'b1;
   localparam logic                 CMD_KEY         = 1'b0;
   localparam logic                 CMD_MSG         = 1'b1;
   localparam logic [LEN_W-1:0]     MAX_LEN         = 7'd64;
   localparam logic [63:0]          PARAM_BASE      = 64'h0000_0000_0101_0000;

   localparam logic [63:0] IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [3:0] SIGMA [10][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

   // Message word used by a half G step; a step is round * 16 + position.
   function automatic logic [3:0] msg_index(input logic [STEP_W-1:0] step);
      logic [3:0] rnd;
      rnd = step[7:4];
      if (rnd >= 4'd10) rnd = rnd - 4'd10;
      return SIGMA[rnd][step[3:0]];
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_LOAD, ST_ROUND, ST_FINISH, ST_DIGEST, ST_EMIT
   } state_type;

   typedef struct packed {
      logic              capture;
      logic              start;
      logic              write_chunk;
      logic              drop;
      logic              cmp_load;
      logic              cmp_step;
      logic              cmp_finish;
      logic              cmp_final;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] rd_step;
      logic              out_load;
      logic [2:0]        out_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic rem_zero;
      logic is_key;
      logic key_ok;
      logic buf_full;
      logic last;
      logic out_last;
   } dp_sts_type;

endpackage

// ----- design/b2b_if.sv -----
// Request and response channel interfaces of the BLAKE2b hash engine.
interface b2b_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [b2b_pkg::DATA_W-1:0]   data_bytes;
   logic [b2b_pkg::CNT_W-1:0]    byte_count;
   logic                         last;
   modport source (output valid, cmd, data_bytes, byte_count, last, input ready);
   modport sink   (input valid, cmd, data_bytes, byte_count, last, output ready);
endinterface

interface b2b_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [b2b_pkg::DATA_W-1:0]   digest_word;
   logic [b2b_pkg::CNT_W-1:0]    digest_bytes;
   logic                         last_word;
   modport source (output valid, digest_word, digest_bytes, last_word, input ready);
   modport sink   (input valid, digest_word, digest_bytes, last_word, output ready);
endinterface

// ----- design/b2b_datapath.sv -----
// Datapath: configuration, block buffer memory, counters and the half G round unit.
module b2b_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [b2b_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [b2b_pkg::LEN_W-1:0]       csr_wdata,
   input  logic                            req_cmd,
   input  logic [b2b_pkg::DATA_W-1:0]      req_data_bytes,
   input  logic [b2b_pkg::CNT_W-1:0]       req_byte_count,
   input  logic                            req_last,
   input  b2b_pkg::dp_cmd_type             cmd,
   output b2b_pkg::dp_sts_type             sts,
   output logic [b2b_pkg::DATA_W-1:0]      rsp_digest_word,
   output logic [b2b_pkg::CNT_W-1:0]       rsp_digest_bytes,
   output logic                            rsp_last_word
);
   import b2b_pkg::*;

   logic [LEN_W-1:0]  hash_len_ff, key_len_ff, eff_hash_ff, eff_key_ff;
   logic [LEN_W-1:0]  hl_c, kl_c, key_pos_ff, pos_c, key_room_c;
   logic [FILL_W-1:0] fill_ff;
   logic              busy_ff, msg_seen_ff;
   logic [15:0]       vmask_ff;
   logic [63:0]       cnt_lo_ff, cnt_hi_ff, cnt_lo_in, cnt_hi_in;
   logic [64:0]       lo_sum_c;
   logic [FILL_W-1:0] nbytes_c;
   logic [63:0]       chain_ff [8];
   logic [63:0]       v_ff [16];
   logic [63:0]       v_in [16];
   logic [63:0]       t_c [16];
   logic [63:0]       mem [16];
   logic [63:0]       rdata_ff, m_c;
   logic              rvalid_ff;
   logic              item_cmd_ff, last_ff;
   logic [63:0]       data_ff;
   logic [CNT_W-1:0]  rem_ff, n_c, chunk_c, room_c;
   logic [2:0]        off_c;
   logic [3:0]        word_c, rd_idx_c;
   logic [15:0]       mask_c;
   logic [7:0]        be_c;
   logic [63:0]       wdata_c;
   logic [63:0]       a1, b1, c1, d1, dx, bx;
   logic [1:0]        amt_c [4];
   logic [LEN_W-1:0]  obytes_c;
   logic              olast_c;
   logic [63:0]       oword_c;

   always_comb begin
      hl_c = hash_len_ff;
      if (hl_c == '0) hl_c = 7'd1;
      if (hl_c > MAX_LEN) hl_c = MAX_LEN;
      kl_c = (key_len_ff > MAX_LEN) ? MAX_LEN : key_len_ff;
      n_c = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
   end

   always_comb begin
      pos_c = (item_cmd_ff == CMD_KEY) ? key_pos_ff : fill_ff[LEN_W-1:0];
      off_c = pos_c[2:0];
      word_c = pos_c[6:3];
      room_c = 4'd8 - {1'b0, off_c};
      key_room_c = eff_key_ff - key_pos_ff;
      chunk_c = (rem_ff < room_c) ? rem_ff : room_c;
      if (item_cmd_ff == CMD_KEY && {3'b000, chunk_c} > key_room_c)
         chunk_c = key_room_c[CNT_W-1:0];
      mask_c = (16'd1 << chunk_c) - 16'd1;
      be_c = 8'(mask_c << off_c);
      wdata_c = data_ff << {off_c, 3'b000};
   end

   always_comb begin
      nbytes_c = cmd.cmp_final ? fill_ff : FILL_W'(BLOCK_BYTES);
      lo_sum_c = {1'b0, cnt_lo_ff} + {57'd0, nbytes_c};
      cnt_lo_in = lo_sum_c[63:0];
      cnt_hi_in = cnt_hi_ff + {63'd0, lo_sum_c[64]};
   end

   // Half G step on the fixed column; rows rotate after the second half.
   always_comb begin
      m_c = rvalid_ff ? rdata_ff : 64'd0;
      a1 = v_ff[0] + v_ff[4] + m_c;
      dx = v_ff[12] ^ a1;
      d1 = cmd.step[0] ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
      c1 = v_ff[8] + d1;
      bx = v_ff[4] ^ c1;
      b1 = cmd.step[0] ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
      t_c = v_ff;
      t_c[0] = a1;
      t_c[4] = b1;
      t_c[8] = c1;
      t_c[12] = d1;
      for (int i = 0; i < 4; i++) begin
         if (cmd.step[3:0] == 4'd7) amt_c[i] = 2'(i + 1);
         else if (cmd.step[3:0] == 4'd15) amt_c[i] = 2'(5 - i);
         else amt_c[i] = 2'd1;
      end
      v_in = t_c;
      if (cmd.step[0]) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               v_in[4*i+j] = t_c[{2'(i), 2'(2'(j) + amt_c[i])}];
            end
         end
      end
   end

   assign rd_idx_c = msg_index(cmd.rd_step);

   always_comb begin
      olast_c = ({1'b0, cmd.out_idx} == 4'((eff_hash_ff - 7'd1) >> 3));
      obytes_c = olast_c ? (eff_hash_ff - {1'b0, cmd.out_idx, 3'b000}) : 7'd8;
      oword_c = chain_ff[cmd.out_idx] & ~(64'hFFFF_FFFF_FFFF_FFFF << {obytes_c, 3'b000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_len_ff <= MAX_LEN;
         key_len_ff  <= '0;
         busy_ff     <= 1'b0;
         vmask_ff    <= '0;
         rem_ff      <= '0;
         last_ff     <= 1'b0;
         rvalid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_HASH_LENGTH: hash_len_ff <= csr_wdata;
               CSR_KEY_LENGTH:  key_len_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.capture) begin
            rem_ff  <= n_c;
            last_ff <= req_last;
         end
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            vmask_ff <= '0;
         end
         if (cmd.write_chunk) begin
            vmask_ff[word_c] <= 1'b1;
            rem_ff <= rem_ff - chunk_c;
         end
         if (cmd.drop) rem_ff <= '0;
         if (cmd.cmp_finish) begin
            if (cmd.cmp_final) busy_ff <= 1'b0;
            else vmask_ff <= '0;
         end
         rvalid_ff <= vmask_ff[rd_idx_c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff <= req_cmd;
         data_ff     <= req_data_bytes;
      end
      if (cmd.start) begin
         eff_hash_ff <= hl_c;
         eff_key_ff  <= kl_c;
         for (int i = 0; i < 8; i++) chain_ff[i] <= IV[i];
         chain_ff[0] <= IV[0] ^ PARAM_BASE ^ {49'd0, kl_c, 8'd0} ^ {57'd0, hl_c};
         cnt_lo_ff   <= '0;
         cnt_hi_ff   <= '0;
         fill_ff     <= (kl_c != '0) ? FILL_W'(BLOCK_BYTES) : '0;
         key_pos_ff  <= '0;
         msg_seen_ff <= 1'b0;
      end
      if (cmd.write_chunk) begin
         data_ff <= data_ff >> {chunk_c, 3'b000};
         if (item_cmd_ff == CMD_KEY) begin
            key_pos_ff <= key_pos_ff + {3'b000, chunk_c};
         end else begin
            fill_ff     <= fill_ff + {4'd0, chunk_c};
            msg_seen_ff <= 1'b1;
         end
      end
      if (cmd.cmp_load) begin
         cnt_lo_ff <= cnt_lo_in;
         cnt_hi_ff <= cnt_hi_in;
         for (int i = 0; i < 8; i++) begin
            v_ff[i]   <= chain_ff[i];
            v_ff[i+8] <= IV[i];
         end
         v_ff[12] <= IV[4] ^ cnt_lo_in;
         v_ff[13] <= IV[5] ^ cnt_hi_in;
         v_ff[14] <= cmd.cmp_final ? ~IV[6] : IV[6];
      end
      if (cmd.cmp_step) v_ff <= v_in;
      if (cmd.cmp_finish) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] ^ v_ff[i] ^ v_ff[i+8];
         if (!cmd.cmp_final) fill_ff <= '0;
      end
      if (cmd.out_load) begin
         rsp_digest_word  <= oword_c;
         rsp_digest_bytes <= obytes_c[CNT_W-1:0];
         rsp_last_word    <= olast_c;
      end
   end

   // Block buffer: byte-lane writes, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write_chunk) begin
         for (int b = 0; b < 8; b++) begin
            if (be_c[b] || !vmask_ff[word_c])
               mem[word_c][8*b +: 8] <= be_c[b] ? wdata_c[8*b +: 8] : 8'h00;
         end
      end
      rdata_ff <= mem[rd_idx_c];
   end

   always_comb begin
      sts.busy     = busy_ff;
      sts.rem_zero = (rem_ff == '0);
      sts.is_key   = (item_cmd_ff == CMD_KEY);
      sts.key_ok   = (eff_key_ff != '0) && !msg_seen_ff && (key_pos_ff < eff_key_ff);
      sts.buf_full = (fill_ff == FILL_W'(BLOCK_BYTES));
      sts.last     = last_ff;
      sts.out_last = rsp_last_word;
   end

endmodule

// ----- design/b2b_controller.sv -----
// Controller state machine sequencing byte writes, compressions and digest output.
module b2b_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  b2b_pkg::dp_sts_type  sts,
   output b2b_pkg::dp_cmd_type  cmd
);
   import b2b_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [2:0]        k_ff, k_in;
   logic              final_ff, final_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_WRITE;
         ST_WRITE: begin
            if (sts.rem_zero) state_in = sts.last ? ST_LOAD : ST_IDLE;
            else if (!sts.is_key && sts.buf_full) state_in = ST_LOAD;
         end
         ST_LOAD:   state_in = ST_ROUND;
         ST_ROUND:  if (step_ff == LAST_STEP) state_in = ST_FINISH;
         ST_FINISH: state_in = final_ff ? ST_DIGEST : ST_WRITE;
         ST_DIGEST: state_in = ST_EMIT;
         ST_EMIT:   if (rsp_ready && sts.out_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      step_in = step_ff;
      k_in = k_ff;
      final_in = final_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.step = step_ff;
      cmd.cmp_final = final_ff;
      cmd.out_idx = k_ff;
      cmd.rd_step = step_ff + 8'd1;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
            cmd.start = req_valid && !sts.busy;
         end
         ST_WRITE: begin
            if (sts.rem_zero) begin
               final_in = 1'b1;
            end else if (sts.is_key) begin
               cmd.write_chunk = sts.key_ok;
               cmd.drop = !sts.key_ok;
            end else if (sts.buf_full) begin
               final_in = 1'b0;
            end else begin
               cmd.write_chunk = 1'b1;
            end
         end
         ST_LOAD: begin
            cmd.cmp_load = 1'b1;
            cmd.rd_step = '0;
            step_in = '0;
         end
         ST_ROUND: begin
            cmd.cmp_step = 1'b1;
            step_in = step_ff + 8'd1;
         end
         ST_FINISH: cmd.cmp_finish = 1'b1;
         ST_DIGEST: begin
            cmd.out_load = 1'b1;
            cmd.out_idx = '0;
            k_in = 3'd1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready && !sts.out_last) begin
               cmd.out_load = 1'b1;
               k_in = k_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         k_ff     <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         final_ff <= final_in;
      end
   end

endmodule

// ----- design/blake2b_hash_engine.sv -----
// Top level of the BLAKE2b hash engine: controller, datapath and channel wiring.
//
// Input transactions on req_if carry up to eight bytes tagged as key or
// message bytes. Key bytes fill the first block when key_length is nonzero.
// A transaction with last set closes the message and produces between one and
// eight response transactions on rsp_if, one per 64-bit digest word.
// The csr port sets hash_length (index 0) and key_length (index 1); both are
// taken up when the first transaction of a message is accepted.
// An input transaction is handled in steps: acceptance, a write for each part
// that falls into one buffer word, a drop of key bytes beyond the key length,
// and a closing step. A full block is compressed as a non-final block only
// when further message bytes arrive; each compression loads the working
// state, runs 192 steps for 12 rounds on the single half G step unit and folds
// the result into the chain value. The final compression is followed by a
// load of the first digest word, which is shown in the next cycle, and each
// further word is shown in the cycle after the previous one is taken.
// Reset clears the control state and the configuration registers to a
// digest length of 64 bytes and no key. While the receiver stalls, the
// current digest word is held and no input transaction is accepted.
module blake2b_hash_engine (
   input  logic                           clock,
   input  logic                           reset,
   b2b_req_if.sink                        req_if,
   b2b_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [b2b_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [b2b_pkg::LEN_W-1:0]      csr_wdata
);
   import b2b_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   b2b_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   b2b_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_if.cmd),
      .req_data_bytes   (req_if.data_bytes),
      .req_byte_count   (req_if.byte_count),
      .req_last         (req_if.last),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_digest_word  (rsp_if.digest_word),
      .rsp_digest_bytes (rsp_if.digest_bytes),
      .rsp_last_word    (rsp_if.last_word)
   );

endmodule
